### src/esd_pkg.sv
// Shared types, constants and character helpers for the escape sequence decoder.
// No dependencies; used by esd_decode and escape_sequence_decoder_core.
`default_nettype none

package esd_pkg;

  // Most results one input beat can produce: a pending digit byte, the
  // character itself and the end-of-string marker.
  localparam int unsigned MaxResults = 3;
  localparam int unsigned CountW     = $clog2(MaxResults + 1);

  // Result queue between the decoder and the output port.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned QCountW    = $clog2(QueueDepth + 1);

  // Character codes used by the decoder.
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChQuote     = 8'h27;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChLowA      = 8'h61;
  localparam logic [7:0] ChLowB      = 8'h62;
  localparam logic [7:0] ChLowF      = 8'h66;
  localparam logic [7:0] ChLowN      = 8'h6E;
  localparam logic [7:0] ChLowR      = 8'h72;
  localparam logic [7:0] ChLowT      = 8'h74;
  localparam logic [7:0] ChLowV      = 8'h76;
  localparam logic [7:0] ChLowX      = 8'h78;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChSeven     = 8'h37;
  localparam logic [7:0] ChNine      = 8'h39;
  localparam logic [7:0] ChUpA       = 8'h41;
  localparam logic [7:0] ChUpF       = 8'h46;

  // Control bytes produced by the simple escapes.
  localparam logic [7:0] ByteBell    = 8'h07;
  localparam logic [7:0] ByteBs      = 8'h08;
  localparam logic [7:0] ByteFf      = 8'h0C;
  localparam logic [7:0] ByteLf      = 8'h0A;
  localparam logic [7:0] ByteCr      = 8'h0D;
  localparam logic [7:0] ByteTab     = 8'h09;
  localparam logic [7:0] ByteVtab    = 8'h0B;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_END_OK  = 2'd1,
    KIND_END_ERR = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] byte_value;
  } result_t;

  // Everything one input beat produces, in emission order from slot 0.
  typedef struct packed {
    logic [CountW-1:0]             count;
    result_t [MaxResults-1:0]      res;
  } step_t;

  function automatic logic is_octal(logic [7:0] c);
    return (c >= ChZero) && (c <= ChSeven);
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return ((c >= ChZero) && (c <= ChNine)) ||
           ((c >= ChLowA) && (c <= ChLowF)) ||
           ((c >= ChUpA) && (c <= ChUpF));
  endfunction

  // Value of a hex digit; only meaningful when is_hex() holds.
  function automatic logic [3:0] hex_value(logic [7:0] c);
    logic [7:0] v;
    if (c <= ChNine) begin
      v = c - ChZero;
    end else if (c >= ChLowA) begin
      v = c - ChLowA + 8'd10;
    end else begin
      v = c - ChUpA + 8'd10;
    end
    return v[3:0];
  endfunction

  function automatic logic simple_escape_ok(logic [7:0] c);
    logic ok;
    case (c)
      ChQuote, ChDquote, ChBackslash, ChLowA, ChLowB,
      ChLowF, ChLowN, ChLowR, ChLowT, ChLowV: ok = 1'b1;
      default:                                ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic [7:0] simple_escape_value(logic [7:0] c);
    logic [7:0] v;
    case (c)
      ChLowA:  v = ByteBell;
      ChLowB:  v = ByteBs;
      ChLowF:  v = ByteFf;
      ChLowN:  v = ByteLf;
      ChLowR:  v = ByteCr;
      ChLowT:  v = ByteTab;
      ChLowV:  v = ByteVtab;
      default: v = c;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### src/esd_decode.sv
// Escape decoding state machine: mode, digit accumulator and error flag,
// plus the combinational decision of one input beat. Depends on esd_pkg.
`default_nettype none

module esd_decode (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_en_i,
  input  wire logic [7:0]    char_code_i,
  input  wire logic          has_char_i,
  input  wire logic          end_of_string_i,
  output esd_pkg::step_t     step_o
);
  import esd_pkg::*;

  typedef enum logic [2:0] {
    MODE_PLAIN = 3'd0,
    MODE_ESC   = 3'd1,
    MODE_HEX0  = 3'd2,
    MODE_HEX1  = 3'd3,
    MODE_OCT1  = 3'd4,
    MODE_OCT2  = 3'd5
  } mode_e;

  mode_e      mode_q, mode_d, mode_m;
  logic [8:0] acc_q, acc_d, acc_m;
  logic       err_q, err_d, err_m;
  step_t      step;
  logic       reproc;

  // Decide the results and the next state for the beat at the inputs.
  always_comb begin
    mode_m     = mode_q;
    acc_m      = acc_q;
    err_m      = err_q;
    step       = '0;
    reproc     = 1'b0;

    if (has_char_i && !err_q) begin
      case (mode_q)
        MODE_ESC: begin
          if (simple_escape_ok(char_code_i)) begin
            step.res[step.count] = '{kind: KIND_BYTE,
                                     byte_value: simple_escape_value(char_code_i)};
            step.count           = step.count + 1'b1;
            mode_m               = MODE_PLAIN;
          end else if (char_code_i == ChLowX) begin
            acc_m  = '0;
            mode_m = MODE_HEX0;
          end else if (is_octal(char_code_i)) begin
            acc_m  = {6'd0, char_code_i[2:0]};
            mode_m = MODE_OCT1;
          end else begin
            err_m  = 1'b1;
            mode_m = MODE_PLAIN;
            acc_m  = '0;
          end
        end
        MODE_HEX0: begin
          if (is_hex(char_code_i)) begin
            acc_m  = {5'd0, hex_value(char_code_i)};
            mode_m = MODE_HEX1;
          end else begin
            err_m  = 1'b1;
            mode_m = MODE_PLAIN;
            acc_m  = '0;
          end
        end
        MODE_HEX1: begin
          if (is_hex(char_code_i)) begin
            step.res[step.count] = '{kind: KIND_BYTE,
                                     byte_value: {acc_q[3:0], hex_value(char_code_i)}};
          end else begin
            step.res[step.count] = '{kind: KIND_BYTE, byte_value: acc_q[7:0]};
            reproc               = 1'b1;
          end
          step.count = step.count + 1'b1;
          mode_m     = MODE_PLAIN;
          acc_m      = '0;
        end
        MODE_OCT1: begin
          if (is_octal(char_code_i)) begin
            acc_m  = {acc_q[5:0], char_code_i[2:0]};
            mode_m = MODE_OCT2;
          end else begin
            step.res[step.count] = '{kind: KIND_BYTE, byte_value: acc_q[7:0]};
            step.count           = step.count + 1'b1;
            reproc               = 1'b1;
            mode_m               = MODE_PLAIN;
            acc_m                = '0;
          end
        end
        MODE_OCT2: begin
          if (is_octal(char_code_i)) begin
            // Three octal digits: the value is truncated to eight bits.
            step.res[step.count] = '{kind: KIND_BYTE,
                                     byte_value: {acc_q[4:0], char_code_i[2:0]}};
          end else begin
            step.res[step.count] = '{kind: KIND_BYTE, byte_value: acc_q[7:0]};
            reproc               = 1'b1;
          end
          step.count = step.count + 1'b1;
          mode_m     = MODE_PLAIN;
          acc_m      = '0;
        end
        default: begin
          reproc = 1'b1;
          mode_m = MODE_PLAIN;
          acc_m  = '0;
        end
      endcase

      // The character is plain text: pass it on or open a new escape.
      if (reproc) begin
        if (char_code_i == ChBackslash) begin
          mode_m = MODE_ESC;
        end else begin
          step.res[step.count] = '{kind: KIND_BYTE, byte_value: char_code_i};
          step.count           = step.count + 1'b1;
        end
      end
    end

    // End of string: flush a pending digit run, then report the outcome.
    if (end_of_string_i) begin
      if (!err_m) begin
        if (mode_m == MODE_ESC || mode_m == MODE_HEX0) begin
          err_m = 1'b1;
        end else if (mode_m == MODE_HEX1 || mode_m == MODE_OCT1 ||
                     mode_m == MODE_OCT2) begin
          step.res[step.count] = '{kind: KIND_BYTE, byte_value: acc_m[7:0]};
          step.count           = step.count + 1'b1;
        end
      end
      step.res[step.count] = '{kind: (err_m ? KIND_END_ERR : KIND_END_OK),
                               byte_value: 8'd0};
      step.count           = step.count + 1'b1;
      mode_m               = MODE_PLAIN;
      acc_m                = '0;
      err_m                = 1'b0;
    end
  end

  // State advances only on an accepted beat.
  always_comb begin
    mode_d = step_en_i ? mode_m : mode_q;
    acc_d  = step_en_i ? acc_m  : acc_q;
    err_d  = step_en_i ? err_m  : err_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
      acc_q  <= '0;
      err_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      err_q  <= err_d;
    end
  end

  assign step_o = step;

  // An accepted end of string always leaves the decoder in its reset state.
  a_eos_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && end_of_string_i |=> mode_q == MODE_PLAIN && acc_q == '0 && !err_q)
    else $error("decoder state not cleared after end of string");

  // After an error, characters are dropped until the end marker.
  a_err_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && err_q && !end_of_string_i |-> step.count == '0)
    else $error("result produced while a string is in error");

  // The accumulator only holds digits while a digit run is open.
  a_acc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_PLAIN || mode_q == MODE_ESC || mode_q == MODE_HEX0 |-> acc_q == '0)
    else $error("stale digit accumulator outside a digit run");

endmodule

`default_nettype wire

### src/escape_sequence_decoder_core.sv
// Throughput: one input beat per cycle while each beat yields one result and the
// output is not stalled; a beat may yield up to three results, which leave through
// a four-entry result queue at one per cycle while the output is not stalled, and
// the input stalls while more than one result waits.
// Reset: rst_ni clears the decoder state and empties the result queue.
// Top level of the escape sequence decoder; depends on esd_pkg and esd_decode.
`default_nettype none

module escape_sequence_decoder_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] char_code_i,
  input  wire logic       has_char_i,
  input  wire logic       end_of_string_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      byte_value_o,
  output logic            last_of_run_o
);
  import esd_pkg::*;

  typedef struct packed {
    result_t res;
    logic    last;
  } entry_t;

  step_t               step;
  logic                in_acc;
  logic                out_acc;
  entry_t              queue_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [QCountW-1:0]  count_q, count_d;
  entry_t              head;

  esd_decode u_decode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_en_i       (in_acc),
    .char_code_i     (char_code_i),
    .has_char_i      (has_char_i),
    .end_of_string_i (end_of_string_i),
    .step_o          (step)
  );

  // Input beats need room for the largest burst of results.
  assign in_stall_o = count_q > QCountW'(QueueDepth - MaxResults);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (in_acc) begin
      wr_ptr_d = wr_ptr_q + PtrW'(step.count);
      count_d  = count_d + QCountW'(step.count);
    end
    if (out_acc) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
      count_d  = count_d - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Write the beat's results in order; the final one carries the run mark.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxResults; i++) begin
      if (in_acc && (CountW'(i) < step.count)) begin
        queue_q[wr_ptr_q + PtrW'(i)] <= '{res:  step.res[i],
                                          last: (CountW'(i + 1) == step.count)};
      end
    end
  end

  // Head of the queue drives the output port.
  assign head          = queue_q[rd_ptr_q];
  assign out_valid_o   = count_q != '0;
  assign kind_o        = head.res.kind;
  assign byte_value_o  = head.res.byte_value;
  assign last_of_run_o = head.last;

  // The queue never holds more than its depth.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCountW'(QueueDepth))
    else $error("result queue overflow");

  // A beat that produced results makes the output valid on the next cycle.
  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && step.count != '0 |=> out_valid_o)
    else $error("queued results not offered");

  // An end marker is always the final result of its beat.
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_BYTE |-> last_of_run_o)
    else $error("end marker not flagged as last of run");

endmodule

`default_nettype wire

### bench/tb_escape_sequence_decoder_core.sv
// Self-checking bench for escape_sequence_decoder_core: directed strings, then random
// escaped strings, broken escapes and noise, checked against a model of the decoder.
// Depends on esd_pkg and the escape_sequence_decoder_core RTL.

module tb_escape_sequence_decoder_core;
  import esd_pkg::*;

  localparam int CycleLimit  = 300000;
  localparam int TotalBeats  = 460;
  localparam int TailBeats   = 50;
  localparam int LongHold    = 60;
  localparam int LongHoldAt  = 100;
  localparam int PauseAt     = 220;
  localparam int ReportCap   = 100;

  localparam logic [7:0] EscChars [10] = '{ChQuote, ChDquote, ChBackslash, ChLowA, ChLowB,
                                           ChLowF, ChLowN, ChLowR, ChLowT, ChLowV};

  typedef enum logic [2:0] {
    MODE_PLAIN, MODE_ESC, MODE_HEX0, MODE_HEX1, MODE_OCT1, MODE_OCT2
  } decode_mode_e;

  typedef struct {
    logic [7:0] code;
    bit         has;
    bit         eos;
    bit         drain_first;
  } char_beat_t;

  typedef struct {
    kind_e      kind;
    logic [7:0] byte_value;
    bit         last;
  } decoded_t;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       in_valid_i      = 1'b0;
  logic       in_stall_o;
  logic [7:0] char_code_i     = 8'h00;
  logic       has_char_i      = 1'b0;
  logic       end_of_string_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i     = 1'b0;
  logic [1:0] kind_o;
  logic [7:0] byte_value_o;
  logic       last_of_run_o;

  char_beat_t   pending_beats[$];
  decoded_t     decoded_due[$];
  decoded_t     beat_results[$];
  logic [7:0]   text_buf[$];

  decode_mode_e dec_mode = MODE_PLAIN;
  logic [8:0]   dec_acc  = '0;
  bit           dec_err  = 1'b0;

  bit drain_next  = 1'b0;
  bit beat_seen   = 1'b0;
  bit hold_done   = 1'b0;
  int stim_beats  = 0;
  int beats_taken = 0;
  int fail_count  = 0;
  int cycle_count = 0;
  int gap_left    = 0;
  int stall_left  = 0;
  int hold_left   = 0;

  escape_sequence_decoder_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .char_code_i     (char_code_i),
    .has_char_i      (has_char_i),
    .end_of_string_i (end_of_string_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .byte_value_o    (byte_value_o),
    .last_of_run_o   (last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Decoder model.

  // Byte for a simple escape letter, or -1 when the letter is not one.
  function automatic int escape_byte(logic [7:0] c);
    case (c)
      ChQuote, ChDquote, ChBackslash: return c;
      ChLowA:  return ByteBell;
      ChLowB:  return ByteBs;
      ChLowF:  return ByteFf;
      ChLowN:  return ByteLf;
      ChLowR:  return ByteCr;
      ChLowT:  return ByteTab;
      ChLowV:  return ByteVtab;
      default: return -1;
    endcase
  endfunction

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= ChZero && c <= ChNine) return c - ChZero;
    if (c >= ChLowA && c <= ChLowF) return c - ChLowA + 10;
    if (c >= ChUpA && c <= ChUpF) return c - ChUpA + 10;
    return -1;
  endfunction

  function automatic bit octal_digit(logic [7:0] c);
    return c >= ChZero && c <= ChSeven;
  endfunction

  function automatic void emit_result(kind_e k, logic [7:0] v);
    decoded_t r;
    r.kind = k;
    r.byte_value = v;
    r.last = 1'b0;
    beat_results = {beat_results, r};
  endfunction

  function automatic void raise_error();
    dec_err = 1'b1;
    dec_mode = MODE_PLAIN;
    dec_acc = '0;
  endfunction

  // One character through the mode machine; a character that ends a digit run is
  // handled again as plain text.
  function automatic void decode_char(logic [7:0] c);
    int v;
    int esc;
    bit settle;
    bit again;
    settle = 1'b1;
    again = 1'b0;
    v = hex_nibble(c);
    esc = escape_byte(c);
    case (dec_mode)
      MODE_ESC: begin
        settle = 1'b0;
        if (esc >= 0) begin
          emit_result(KIND_BYTE, 8'(esc));
          dec_mode = MODE_PLAIN;
        end else if (c == ChLowX) begin
          dec_acc = '0;
          dec_mode = MODE_HEX0;
        end else if (octal_digit(c)) begin
          dec_acc = 9'(c - ChZero);
          dec_mode = MODE_OCT1;
        end else begin
          raise_error();
        end
      end
      MODE_HEX0: begin
        settle = 1'b0;
        if (v >= 0) begin
          dec_acc = 9'(v);
          dec_mode = MODE_HEX1;
        end else begin
          raise_error();
        end
      end
      MODE_HEX1: begin
        if (v >= 0) begin
          emit_result(KIND_BYTE, 8'(dec_acc * 16 + v));
        end else begin
          emit_result(KIND_BYTE, dec_acc[7:0]);
          again = 1'b1;
        end
      end
      MODE_OCT1: begin
        if (octal_digit(c)) begin
          dec_acc = 9'(dec_acc * 8 + (c - ChZero));
          dec_mode = MODE_OCT2;
          settle = 1'b0;
        end else begin
          emit_result(KIND_BYTE, dec_acc[7:0]);
          again = 1'b1;
        end
      end
      MODE_OCT2: begin
        if (octal_digit(c)) begin
          // Three octal digits may exceed a byte; only the low 8 bits survive.
          emit_result(KIND_BYTE, 8'(dec_acc * 8 + (c - ChZero)));
        end else begin
          emit_result(KIND_BYTE, dec_acc[7:0]);
          again = 1'b1;
        end
      end
      default: again = 1'b1;
    endcase
    if (settle) begin
      dec_mode = MODE_PLAIN;
      dec_acc = '0;
      if (again) begin
        if (c == ChBackslash) begin
          dec_mode = MODE_ESC;
        end else begin
          emit_result(KIND_BYTE, c);
        end
      end
    end
  endfunction

  // All results of one input beat, queued in order with the last one marked.
  function automatic void decode_beat(char_beat_t b);
    beat_results.delete();
    if (b.has && !dec_err) decode_char(b.code);
    if (b.eos) begin
      if (!dec_err) begin
        if (dec_mode == MODE_ESC || dec_mode == MODE_HEX0) begin
          dec_err = 1'b1;
        end else if (dec_mode inside {MODE_HEX1, MODE_OCT1, MODE_OCT2}) begin
          emit_result(KIND_BYTE, dec_acc[7:0]);
        end
      end
      emit_result(dec_err ? KIND_END_ERR : KIND_END_OK, 8'h00);
      dec_mode = MODE_PLAIN;
      dec_acc = '0;
      dec_err = 1'b0;
    end
    if (beat_results.size() > 0) beat_results[beat_results.size() - 1].last = 1'b1;
    foreach (beat_results[i]) decoded_due = {decoded_due, beat_results[i]};
  endfunction

  // Stimulus building.

  task automatic add_beat(logic [7:0] c, bit has, bit eos);
    char_beat_t b;
    b.code = c;
    b.has = has;
    b.eos = eos;
    b.drain_first = drain_next;
    drain_next = 1'b0;
    pending_beats = {pending_beats, b};
    if (has || eos) stim_beats++;
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) text_buf = {text_buf, s[i]};
  endtask

  // Sends the buffered text; the end marker rides on the last character or
  // follows as a beat of its own.
  task automatic send_text(bit end_on_last, bit bubbles);
    int n;
    n = text_buf.size();
    for (int i = 0; i < n; i++) begin
      if (bubbles && $urandom_range(0, 15) == 0) add_beat(8'($urandom), 1'b0, 1'b0);
      add_beat(text_buf[i], 1'b1, end_on_last && i == n - 1);
    end
    if (!end_on_last || n == 0) add_beat(8'($urandom), 1'b0, 1'b1);
    text_buf.delete();
  endtask

  function automatic logic [7:0] hex_char(int v, bit upper);
    if (v < 10) return 8'(ChZero + v);
    return 8'((upper ? ChUpA : ChLowA) + v - 10);
  endfunction

  // One well-formed piece of text: a plain character or a complete escape.
  task automatic put_token();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1: begin
        do c = 8'($urandom_range(32, 126)); while (c == ChBackslash);
        text_buf = {text_buf, c};
      end
      2: begin
        do c = 8'($urandom); while (c == ChBackslash);
        text_buf = {text_buf, c};
      end
      3, 4: begin
        text_buf = {text_buf, ChBackslash};
        text_buf = {text_buf, EscChars[$urandom_range(0, 9)]};
      end
      5, 6: begin
        text_buf = {text_buf, ChBackslash};
        text_buf = {text_buf, ChLowX};
        repeat ($urandom_range(1, 2))
          text_buf = {text_buf, hex_char($urandom_range(0, 15), $urandom_range(0, 1))};
      end
      default: begin
        text_buf = {text_buf, ChBackslash};
        repeat ($urandom_range(1, 3))
          text_buf = {text_buf, 8'(ChZero + $urandom_range(0, 7))};
      end
    endcase
  endtask

  // A bad escape, a \x with no digit, or an escape cut off by the end of the string.
  task automatic put_broken();
    logic [7:0] c;
    int how;
    how = $urandom_range(0, 3);
    text_buf = {text_buf, ChBackslash};
    case (how)
      0: begin
        do c = 8'($urandom);
        while (escape_byte(c) >= 0 || c == ChLowX || octal_digit(c));
        text_buf = {text_buf, c};
      end
      1: begin
        text_buf = {text_buf, ChLowX};
        do c = 8'($urandom); while (hex_nibble(c) >= 0);
        text_buf = {text_buf, c};
      end
      2: text_buf = {text_buf, ChLowX};
      default: ;
    endcase
    // Text after an error is ignored up to the end marker.
    if (how < 2) repeat ($urandom_range(0, 3)) put_token();
  endtask

  // Idling is off in the tail, during the long receiver hold, and in every
  // fourth stretch of cycles.
  function automatic bit idling_allowed();
    return pending_beats.size() > TailBeats && hold_left == 0 && (cycle_count / 200) % 4 != 3;
  endfunction

  // Driver: presents one beat at a time and holds it until it is taken.
  always @(negedge clk_i) begin : driver
    char_beat_t b;
    if (rst_ni && (!in_valid_i || beat_seen)) begin
      beat_seen = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_beats.size() == 0 ||
                   (pending_beats[0].drain_first && decoded_due.size() != 0)) begin
        in_valid_i <= 1'b0;
      end else begin
        b = pending_beats.pop_front();
        char_code_i     <= b.code;
        has_char_i      <= b.has;
        end_of_string_i <= b.eos;
        in_valid_i      <= 1'b1;
        if (idling_allowed() && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 15);
      end
    end
  end

  // Receiver: random stall bursts plus one long hold that backs the block up.
  always @(negedge clk_i) begin : receiver
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!hold_done && beats_taken >= LongHoldAt) begin
        hold_done = 1'b1;
        hold_left = LongHold - 1;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Monitor: every input beat advances the model, every output beat is checked.
  always @(posedge clk_i) begin : monitor
    char_beat_t b;
    decoded_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        b.code = char_code_i;
        b.has = has_char_i;
        b.eos = end_of_string_i;
        b.drain_first = 1'b0;
        decode_beat(b);
        beat_seen = 1'b1;
        beats_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (decoded_due.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportCap)
            $display("%0t: unexpected result: expected none, actual kind=%0d byte=%02h last=%0b",
                     $time, kind_o, byte_value_o, last_of_run_o);
        end else begin
          want = decoded_due.pop_front();
          if (kind_o !== want.kind || byte_value_o !== want.byte_value ||
              last_of_run_o !== want.last) begin
            fail_count++;
            if (fail_count <= ReportCap)
              $display("%0t: expected kind=%0d byte=%02h last=%0b, actual kind=%0d byte=%02h last=%0b",
                       $time, want.kind, want.byte_value, want.last,
                       kind_o, byte_value_o, last_of_run_o);
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int sel;
    bit paused;
    paused = 1'b0;

    // Directed strings: digit extremes, octal truncation, a hex run cut by a
    // backslash that is left open at the end, an unknown escape, an empty string,
    // an idle beat, extreme plain bytes, a bare \x at the end, a pending octal run.
    put_str("\\xFf");
    send_text(1'b1, 1'b0);
    put_str("\\777");
    send_text(1'b1, 1'b0);
    put_str("\\x0\\");
    send_text(1'b0, 1'b0);
    put_str("\\qz");
    send_text(1'b1, 1'b0);
    send_text(1'b0, 1'b0);
    add_beat(8'hA5, 1'b0, 1'b0);
    text_buf = {text_buf, 8'h00};
    text_buf = {text_buf, 8'hFF};
    send_text(1'b1, 1'b0);
    put_str("\\x");
    send_text(1'b1, 1'b0);
    put_str("\\12");
    send_text(1'b1, 1'b0);

    // Random part: mostly well-formed strings, some broken ones, some noise.
    while (stim_beats < TotalBeats) begin
      if (!paused && stim_beats >= PauseAt) begin
        drain_next = 1'b1;
        paused = 1'b1;
      end
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        repeat ($urandom_range(1, 6))
          add_beat(8'($urandom), $urandom_range(0, 3) != 0, $urandom_range(0, 4) == 0);
      end else begin
        repeat ($urandom_range(0, 5)) put_token();
        if (sel <= 2) put_broken();
        send_text($urandom_range(0, 1), 1'b1);
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    while (pending_beats.size() != 0 || in_valid_i) @(posedge clk_i);
    while (decoded_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (fail_count == 0 && decoded_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
src/esd_pkg.sv
src/esd_decode.sv
src/escape_sequence_decoder_core.sv
bench/tb_escape_sequence_decoder_core.sv
